// File: rtl/ffa_pkg.sv
// ============================================================================
// ffa_pkg
// Shared codes, field widths and controller/datapath interface structs for
// the first-fit free-list allocator.
// ============================================================================
package ffa_pkg;

    // Item field widths
    localparam int KIND_W = 2;
    localparam int REQ_W  = 17;
    localparam int OFF_W  = 16;
    localparam int ST_W   = 2;

    // Rounded request width: a 17-bit request rounded up to a block (<= 4096)
    localparam int SZ_W = 18;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOMEM      = 2'd1;
    localparam logic [ST_W-1:0] ST_NULL       = 2'd2;
    localparam logic [ST_W-1:0] ST_MISALIGNED = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic            load;       // latch input item
        logic            wr_init;    // heap init: descriptor 0 and list head
        logic            wr_free;    // push freed segment on list head
        logic            walk_init;  // start walk at list head
        logic            rd_issue;   // read descriptor at cursor
        logic            step;       // advance cursor to next link
        logic            wr_link;    // relink predecessor or list head
        logic            wr_new;     // write split-off descriptor
        logic            wr_blk;     // write allocated descriptor
        logic            set_res;    // capture result
        logic            res_pay;    // result carries the payload offset
        logic [ST_W-1:0] res_status;
        logic            out_load;   // move result into output register
    } ffa_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              null_ptr;
        logic              misaligned;
        logic              cur_valid;
        logic              walk_done;
        logic              fits;
        logic              split;
        logic              out_free;
    } ffa_sts_t;

endpackage

// File: rtl/first_fit_free_list_allocator.sv
// ============================================================================
// first_fit_free_list_allocator
// First-fit heap allocator: init, allocate (walk + split/unlink) and free
// (push on list head, no coalescing) over a descriptor store in block RAM.
// ============================================================================
//
//  Channel  | Direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+----------------------
//  s_axis   | in        | [16:0] request_bytes, [32:17] free_off | [1:0] kind, [2] null
//  m_axis   | out       | [15:0] payload_offset, [17:16] status  | -
//
//  Sequencing: one item at a time. Init, free and unused kinds pass from
//  acceptance through dispatch to the result. Allocate walks the free list,
//  reading each descriptor in a walk state and comparing it in a check
//  state; a fit relinks, writes a split-off descriptor if the segment is
//  split, then writes the granted block; no fit gives a no-memory result.
//  The next item can be accepted in the cycle after the result is loaded.
//  Reset: list empty, no clearing pass; descriptors are undefined until
//  written; an init item writes descriptor 0.
//  Stalls: a result waits in the output register while the next item is
//  accepted; that item finishes only once the output register is free.
//  HEAP_BYTES, BLOCK_BYTES and DESCR_BYTES must be powers of two; the block does not check this.
//
module first_fit_free_list_allocator #(
    parameter int HEAP_BYTES  = 65536,
    parameter int BLOCK_BYTES = 64,
    parameter int DESCR_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_bytes[16:0], free_offset[32:17], pad
    input  logic [2:0]  s_axis_tuser,   // kind[1:0], null_pointer[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // payload_offset[15:0], status[17:16], pad
);
    import ffa_pkg::*;

    ffa_cmd_t          cmd;
    ffa_sts_t          sts;
    logic [OFF_W-1:0]  payload_offset;
    logic [ST_W-1:0]   status;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_datapath #(
        .HEAP_BYTES  (HEAP_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .DESCR_BYTES (DESCR_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (s_axis_tuser[1:0]),
        .request_bytes  (s_axis_tdata[16:0]),
        .free_offset    (s_axis_tdata[32:17]),
        .null_pointer   (s_axis_tuser[2]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .payload_offset (payload_offset),
        .status         (status)
    );

    assign m_axis_tdata = {6'd0, status, payload_offset};

    // Failed results never carry an offset
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status != ST_OK) |-> (payload_offset == '0))
    else $error("nonzero payload on a failed result");

    // One item in flight: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in progress");

    // At most one descriptor update step per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_init, cmd.wr_free, cmd.wr_link, cmd.wr_new, cmd.wr_blk}))
    else $error("conflicting descriptor writes");

    // A result is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output");

endmodule

// File: rtl/ffa_datapath.sv
// ============================================================================
// ffa_datapath
// Descriptor memories, list head, walk cursor, size arithmetic and the
// output register.
// ============================================================================
module ffa_datapath #(
    parameter int HEAP_BYTES  = 65536,
    parameter int BLOCK_BYTES = 64,
    parameter int DESCR_BYTES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffa_pkg::ffa_cmd_t          cmd,
    output ffa_pkg::ffa_sts_t          sts,
    input  logic [ffa_pkg::KIND_W-1:0] kind,
    input  logic [ffa_pkg::REQ_W-1:0]  request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]  free_offset,
    input  logic                       null_pointer,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [ffa_pkg::OFF_W-1:0]  payload_offset,
    output logic [ffa_pkg::ST_W-1:0]   status
);
    import ffa_pkg::*;

    localparam int DEPTH     = HEAP_BYTES / DESCR_BYTES;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int LOG_D     = $clog2(DESCR_BYTES);
    localparam int LOG_B     = $clog2(BLOCK_BYTES);
    localparam int SIZE_W    = $clog2(HEAP_BYTES + 1);
    localparam int CMP_W     = (SIZE_W > SZ_W ? SIZE_W : SZ_W) + 1;
    localparam int OFFX_W    = (OFF_W > SIZE_W ? OFF_W : SIZE_W) + 1;
    localparam int NB_W      = (IDX_W > SZ_W ? IDX_W : SZ_W) + 1;
    localparam int PAY_W     = (OFF_W > IDX_W + 1 + LOG_D) ? OFF_W : IDX_W + 1 + LOG_D;
    localparam int OVERHEAD  = BLOCK_BYTES + DESCR_BYTES;
    localparam int INIT_SIZE = (HEAP_BYTES > OVERHEAD) ? HEAP_BYTES - OVERHEAD : 0;
    localparam int SPLIT_MIN = DESCR_BYTES + BLOCK_BYTES;

    // Descriptor store, split so link and size write independently
    logic [IDX_W:0]    next_mem [DEPTH];   // {valid, index}
    logic [SIZE_W-1:0] size_mem [DEPTH];

    // Item registers
    logic [KIND_W-1:0] kind_reg;
    logic [SZ_W-1:0]   sz_reg;
    logic [SZ_W-1:0]   sz_next;
    logic [OFF_W-1:0]  off_reg;
    logic              null_reg;

    // List head and walk state
    logic              head_valid_reg;
    logic [IDX_W-1:0]  head_idx_reg;
    logic              cur_valid_reg;
    logic [IDX_W-1:0]  cur_idx_reg;
    logic [IDX_W-1:0]  prev_idx_reg;
    logic              have_prev_reg;
    logic [IDX_W:0]    steps_reg;

    // Registered read data
    logic              rd_next_valid_reg;
    logic [IDX_W-1:0]  rd_next_idx_reg;
    logic [SIZE_W-1:0] rd_size_reg;

    // Result and output registers
    logic [ST_W-1:0]   res_status_reg;
    logic [OFF_W-1:0]  res_payload_reg;
    logic              out_valid_reg;
    logic [OFF_W-1:0]  out_payload_reg;
    logic [ST_W-1:0]   out_status_reg;

    // Arithmetic
    logic [SZ_W-1:0]   req_round;
    logic [CMP_W-1:0]  rem_x;
    logic [SIZE_W-1:0] rem;
    logic [NB_W-1:0]   nb_sum;
    logic [IDX_W-1:0]  nb_idx;
    logic [IDX_W:0]    link_val;
    logic [PAY_W-1:0]  pay_full;
    logic [OFFX_W-1:0] off_x;
    logic [OFFX_W-1:0] off_base;
    logic [IDX_W-1:0]  free_idx;
    logic              misaligned;
    logic              fits;
    logic              split;

    // Memory write ports
    logic              nx_we;
    logic [IDX_W-1:0]  nx_addr;
    logic [IDX_W:0]    nx_data;
    logic              sz_we;
    logic [IDX_W-1:0]  sz_addr;
    logic [SIZE_W-1:0] sz_data;

    // Round the request up to whole blocks
    assign req_round = SZ_W'(request_bytes) + SZ_W'(BLOCK_BYTES - 1);
    assign sz_next   = {req_round[SZ_W-1:LOG_B], LOG_B'(0)};

    assign fits  = CMP_W'(rd_size_reg) >= CMP_W'(sz_reg);
    assign rem_x = CMP_W'(rd_size_reg) - CMP_W'(sz_reg);
    assign rem   = rem_x[SIZE_W-1:0];
    assign split = rem_x >= CMP_W'(SPLIT_MIN);

    // Split descriptor sits right after the allocated payload
    assign nb_sum   = NB_W'(cur_idx_reg) + NB_W'(1) + NB_W'(sz_reg >> LOG_D);
    assign nb_idx   = nb_sum[IDX_W-1:0];
    assign link_val = split ? {1'b1, nb_idx} : {rd_next_valid_reg, rd_next_idx_reg};
    assign pay_full = (PAY_W'(cur_idx_reg) + PAY_W'(1)) << LOG_D;

    // Free address checks
    assign off_x      = OFFX_W'(off_reg);
    assign off_base   = off_x - OFFX_W'(DESCR_BYTES);
    assign free_idx   = IDX_W'(off_base >> LOG_D);
    assign misaligned = (off_reg[LOG_D-1:0] != '0) ||
                        (off_x < OFFX_W'(DESCR_BYTES)) ||
                        (off_base >= OFFX_W'(HEAP_BYTES));

    always_comb
    begin
        nx_we   = 1'b0;
        nx_addr = '0;
        nx_data = '0;
        sz_we   = 1'b0;
        sz_addr = '0;
        sz_data = '0;
        if (cmd.wr_init)
        begin
            nx_we   = 1'b1;
            sz_we   = 1'b1;
            sz_data = SIZE_W'(INIT_SIZE);
        end
        else if (cmd.wr_free)
        begin
            nx_we   = 1'b1;
            nx_addr = free_idx;
            nx_data = {head_valid_reg, head_idx_reg};
        end
        else if (cmd.wr_link)
        begin
            nx_we   = have_prev_reg;
            nx_addr = prev_idx_reg;
            nx_data = link_val;
        end
        else if (cmd.wr_new)
        begin
            nx_we   = 1'b1;
            nx_addr = nb_idx;
            nx_data = {rd_next_valid_reg, rd_next_idx_reg};
            sz_we   = 1'b1;
            sz_addr = nb_idx;
            sz_data = rem - SIZE_W'(DESCR_BYTES);
        end
        else if (cmd.wr_blk)
        begin
            nx_we   = 1'b1;
            nx_addr = cur_idx_reg;
            sz_we   = 1'b1;
            sz_addr = cur_idx_reg;
            sz_data = sz_reg[SIZE_W-1:0];
        end
    end

    // Descriptor memories
    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_addr] <= nx_data;
        if (sz_we)
            size_mem[sz_addr] <= sz_data;
        if (cmd.rd_issue)
        begin
            {rd_next_valid_reg, rd_next_idx_reg} <= next_mem[cur_idx_reg];
            rd_size_reg                          <= size_mem[cur_idx_reg];
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            sz_reg   <= sz_next;
            off_reg  <= free_offset;
            null_reg <= null_pointer;
        end
        if (cmd.walk_init)
        begin
            cur_idx_reg  <= head_idx_reg;
            prev_idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            prev_idx_reg <= cur_idx_reg;
            cur_idx_reg  <= rd_next_idx_reg;
        end
        if (cmd.set_res)
        begin
            res_status_reg  <= cmd.res_status;
            res_payload_reg <= cmd.res_pay ? pay_full[OFF_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            out_payload_reg <= res_payload_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            head_idx_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_init)
            begin
                head_valid_reg <= 1'b1;
                head_idx_reg   <= '0;
            end
            else if (cmd.wr_free)
            begin
                head_valid_reg <= 1'b1;
                head_idx_reg   <= free_idx;
            end
            else if (cmd.wr_link && !have_prev_reg)
            begin
                head_valid_reg <= link_val[IDX_W];
                head_idx_reg   <= link_val[IDX_W-1:0];
            end

            if (cmd.walk_init)
            begin
                cur_valid_reg <= head_valid_reg;
                have_prev_reg <= 1'b0;
                steps_reg     <= '0;
            end
            else if (cmd.step)
            begin
                cur_valid_reg <= rd_next_valid_reg;
                have_prev_reg <= 1'b1;
                steps_reg     <= steps_reg + 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.null_ptr   = null_reg;
    assign sts.misaligned = misaligned;
    assign sts.cur_valid  = cur_valid_reg;
    assign sts.walk_done  = (steps_reg == (IDX_W + 1)'(DEPTH));
    assign sts.fits       = fits;
    assign sts.split      = split;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign payload_offset = out_payload_reg;
    assign status         = out_status_reg;

endmodule

// File: rtl/ffa_ctrl.sv
// ============================================================================
// ffa_ctrl
// Sequencer for init, free and the first-fit allocate walk.
// ============================================================================
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffa_pkg::ffa_sts_t sts,
    output ffa_pkg::ffa_cmd_t cmd
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_CHECK,
        S_LINK,
        S_NEW,
        S_BLK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
                case (sts.kind)
                    KIND_INIT:
                        cmd.wr_init = 1'b1;
                    KIND_ALLOC:
                    begin
                        cmd.set_res   = 1'b0;
                        cmd.walk_init = 1'b1;
                        state_next    = S_WALK;
                    end
                    KIND_FREE:
                    begin
                        if (sts.null_ptr)
                            cmd.res_status = ST_NULL;
                        else if (sts.misaligned)
                            cmd.res_status = ST_MISALIGNED;
                        else
                            cmd.wr_free = 1'b1;
                    end
                    default:
                        cmd.res_status = ST_OK;
                endcase
            end
            S_WALK:
            begin
                if (!sts.cur_valid || sts.walk_done)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOMEM;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.fits)
                    state_next = S_LINK;
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_LINK:
            begin
                cmd.wr_link = 1'b1;
                state_next  = sts.split ? S_NEW : S_BLK;
            end
            S_NEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_BLK;
            end
            S_BLK:
            begin
                cmd.wr_blk     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_pay    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
